// ===== rtl/rnde_pkg.sv =====
// Shared types, constants and helpers of the RGB neighbour-difference edge filter.
`timescale 1ns / 1ps

package rnde_pkg;

  // Default capacity of each line store, in pixels.
  localparam int MAX_WIDTH_DEF = 2048;

  // Field widths fixed by the stream format.
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int CFG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 11;
  localparam int SUM_W     = 12;

  // Smallest image size the filter works on; smaller settings act as this.
  localparam int MIN_SIZE = 3;

  // Centres closer than this to the top or left edge give a zero result.
  localparam int BORDER = 2;

  localparam logic [CHAN_W-1:0] EDGE_MAX = 8'd255;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Packed pixel, blue in the lowest byte, red in the highest.
  typedef logic [PIX_W-1:0] pix_t;

  // One centre pixel with its four neighbours, ready for the arithmetic.
  typedef struct packed {
    pix_t                 center;
    pix_t                 left;
    pix_t                 top;
    pix_t                 right;
    pix_t                 bottom;
    logic                 force_zero;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } edge_job_t;

  // Fill state of the queue, seen by the front part.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_status_t;

  function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/rnde_front.sv =====
// Front part: position counters, both line stores, the pixel window and job building.
`timescale 1ns / 1ps

module rnde_front #(
  parameter int MAX_WIDTH = rnde_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rnde_pkg::CFG_W-1:0]  cfg_width_i,
  input  logic [rnde_pkg::CFG_W-1:0]  cfg_height_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rnde_pkg::pix_t              in_pix_i,
  input  logic                        in_frame_start_i,
  input  rnde_pkg::q_status_t         q_status_i,
  output logic                        push_o,
  output rnde_pkg::edge_job_t         job_o
);
  import rnde_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0] width_eff, height_eff;
  logic [CW-1:0]    col_q, col_d, col_now;
  logic [ROW_W-1:0] row_q, row_d, row_now;
  logic             accept;

  // Stage one: the item whose line store data is being read.
  logic             s1_v_q, s1_byp_q, byp_hit;
  pix_t             s1_pix_q;
  logic [CW-1:0]    s1_c_q;
  logic [ROW_W-1:0] s1_r_q;

  pix_t rd_mid_q, rd_up_q, byp_mid_q, byp_up_q, mid_cur, up_cur;
  pix_t win0_q, win1_q, win2_q, win3_q, win4_q, win5_q;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  logic emit, s1_zero, s1_last;
  logic [CMP_W-1:0] s1_c_ext, w_ext;

  always_comb begin
    if (cfg_height_i < CFG_W'(MIN_SIZE)) begin
      height_eff = CFG_W'(MIN_SIZE);
    end else begin
      height_eff = cfg_height_i;
    end
    if (cfg_width_i < CFG_W'(MIN_SIZE)) begin
      width_eff = CFG_W'(MIN_SIZE);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      width_eff = CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = cfg_width_i;
    end
  end

  // Room is kept for the item in stage one and the one about to enter.
  assign in_ready_o = ((QCNT_W + 1)'(q_status_i.count) + (QCNT_W + 1)'(s1_v_q))
                      <= (QCNT_W + 1)'(QDEPTH - 2);
  assign accept = in_valid_i && in_ready_o;

  assign col_now = in_frame_start_i ? '0 : col_q;
  assign row_now = in_frame_start_i ? '0 : row_q;

  always_comb begin
    col_d = col_now;
    row_d = row_now;
    if (CMP_W'(col_now) + CMP_W'(1) >= CMP_W'(width_eff)) begin
      col_d = '0;
      if ((ROW_W + 1)'(row_now) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(height_eff)) begin
        row_d = '0;
      end else begin
        row_d = row_now + ROW_W'(1);
      end
    end else begin
      col_d = col_now + CW'(1);
    end
  end

  // A read that meets the write of the item just ahead at the same column
  // sees the old entry; the data being written is taken instead.
  assign byp_hit = s1_v_q && (s1_c_q == col_now);
  assign mid_cur = s1_byp_q ? byp_mid_q : rd_mid_q;
  assign up_cur  = s1_byp_q ? byp_up_q  : rd_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      s1_byp_q <= 1'b0;
      win0_q   <= '0;
      win1_q   <= '0;
      win2_q   <= '0;
      win3_q   <= '0;
      win4_q   <= '0;
      win5_q   <= '0;
    end else begin
      s1_v_q <= accept;
      if (accept) begin
        col_q    <= col_d;
        row_q    <= row_d;
        s1_byp_q <= byp_hit;
      end
      if (s1_v_q) begin
        win2_q <= win1_q;
        win1_q <= win0_q;
        win0_q <= mid_cur;
        win4_q <= win3_q;
        win3_q <= up_cur;
        win5_q <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= in_pix_i;
      s1_c_q   <= col_now;
      s1_r_q   <= row_now;
      rd_mid_q <= middle_mem[col_now];
      rd_up_q  <= upper_mem[col_now];
    end
    if (s1_v_q) begin
      upper_mem[s1_c_q]  <= mid_cur;
      middle_mem[s1_c_q] <= s1_pix_q;
      byp_mid_q          <= s1_pix_q;
      byp_up_q           <= mid_cur;
    end
  end

  // The pixel in stage one is the bottom-right corner of the neighbourhood
  // of the centre one row up and one column left.
  assign s1_c_ext = CMP_W'(s1_c_q);
  assign w_ext    = CMP_W'(width_eff);
  assign emit     = (s1_r_q != '0) && (s1_c_q != '0);
  assign s1_zero  = (s1_r_q < ROW_W'(BORDER + 1)) || (s1_c_ext < CMP_W'(BORDER + 1))
                    || (s1_r_q >= height_eff) || (s1_c_ext >= w_ext);
  assign s1_last  = (s1_r_q == height_eff - CFG_W'(1)) && (s1_c_ext == w_ext - CMP_W'(1));

  assign push_o = s1_v_q && emit;

  always_comb begin
    job_o.center     = win0_q;
    job_o.left       = win1_q;
    job_o.top        = win3_q;
    job_o.right      = mid_cur;
    job_o.bottom     = win5_q;
    job_o.force_zero = s1_zero;
    job_o.row        = s1_r_q - ROW_W'(1);
    job_o.col        = COL_OUT_W'(s1_c_q - CW'(1));
    job_o.last       = s1_last;
  end

endmodule

// ===== rtl/rnde_queue.sv =====
// Short job queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module rnde_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rnde_pkg::edge_job_t job_i,
  input  logic                pop_i,
  output rnde_pkg::edge_job_t job_o,
  output rnde_pkg::q_status_t status_o
);
  import rnde_pkg::*;

  edge_job_t         slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o          = slot_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCNT_W'(QDEPTH));

endmodule

// ===== rtl/rnde_back.sv =====
// Back part: sum of absolute channel differences, clamping and the output register.
`timescale 1ns / 1ps

module rnde_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rnde_pkg::edge_job_t           job_i,
  input  logic                          job_valid_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rnde_pkg::CHAN_W-1:0]   edge_value_o,
  output logic [rnde_pkg::ROW_W-1:0]    out_row_o,
  output logic [rnde_pkg::COL_OUT_W-1:0] out_col_o,
  output logic                          frame_last_o
);
  import rnde_pkg::*;

  logic             out_v_q;
  logic [SUM_W-1:0] sum;
  logic [CHAN_W-1:0] edge_val;

  always_comb begin
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = sum
          + SUM_W'(abs_diff8(job_i.left[ch*CHAN_W +: CHAN_W],   job_i.center[ch*CHAN_W +: CHAN_W]))
          + SUM_W'(abs_diff8(job_i.top[ch*CHAN_W +: CHAN_W],    job_i.center[ch*CHAN_W +: CHAN_W]))
          + SUM_W'(abs_diff8(job_i.right[ch*CHAN_W +: CHAN_W],  job_i.center[ch*CHAN_W +: CHAN_W]))
          + SUM_W'(abs_diff8(job_i.bottom[ch*CHAN_W +: CHAN_W], job_i.center[ch*CHAN_W +: CHAN_W]));
    end
    if (job_i.force_zero) begin
      edge_val = '0;
    end else if (sum > SUM_W'(EDGE_MAX)) begin
      edge_val = EDGE_MAX;
    end else begin
      edge_val = sum[CHAN_W-1:0];
    end
  end

  assign pop_o = job_valid_i && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pop_o) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      edge_value_o <= edge_val;
      out_row_o    <= job_i.row;
      out_col_o    <= job_i.col;
      frame_last_o <= job_i.last;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// ===== rtl/rgb_neighbor_difference_edge_map_top.sv =====
// Top level of the RGB four-neighbour absolute-difference edge filter.
`timescale 1ns / 1ps

// The filter takes a raster stream of RGB pixels, one per clock, and for each
// centre pixel sums the absolute blue, green and red differences to its left,
// top, right and bottom neighbours, clamped to 255. A result for the centre one
// row up and one column left leaves after each pixel that is not in row 0 or
// column 0, so a frame gives (height-1)*(width-1) results and the last one is
// marked with tlast; centres in the two top rows or two left columns read zero.
// A pixel is taken in every cycle while the downstream side does not stall. In
// the front part its column is read from both line stores (one read and one
// write port each, with a bypass for a column just written); the job then waits
// in a four-entry queue, and the back part computes the sum into the output
// register. The front part stops taking pixels once the queued jobs and the
// pixel in its own stage add up to three, which happens only while the
// downstream side stalls.
// A tuser bit marks the first pixel of a frame and resets the position; after
// the last pixel of a frame the position wraps on its own. Image width and
// height are set through the configuration port while the stream is idle;
// widths above MAX_WIDTH act as MAX_WIDTH and sizes below three act as three.
// The line stores are not cleared and need no warm-up after reset.
module rgb_neighbor_difference_edge_map_top #(
  parameter int MAX_WIDTH = rnde_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [rnde_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rnde_pkg::CFG_W-1:0]     cfg_data_i,
  // Pixel input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // blue, green, red
  input  logic                           s_axis_tuser,  // frame_start
  // Edge result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // edge_value, out_row, out_col, zero
  output logic                           m_axis_tlast   // frame_last
);
  import rnde_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;

  logic      push, pop;
  edge_job_t job_in, job_head;
  q_status_t q_status;

  logic [CHAN_W-1:0]    edge_value;
  logic [ROW_W-1:0]     out_row;
  logic [COL_OUT_W-1:0] out_col;

  // Configuration registers, to be written only while the stream is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1920);
      height_q <= CFG_W'(1080);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rnde_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_width_i      (width_q),
    .cfg_height_i     (height_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_pix_i         (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser),
    .q_status_i       (q_status),
    .push_o           (push),
    .job_o            (job_in)
  );

  rnde_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_head),
    .status_o (q_status)
  );

  rnde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .job_valid_i  (!q_status.empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .edge_value_o (edge_value),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .frame_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_col, out_row, edge_value};

`ifndef SYNTH
  // The front part must never send a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("job pushed into a full queue");

  // No job is taken from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  // Centres in the two top rows always give a zero edge value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (edge_value != '0)) |-> (out_row >= ROW_W'(BORDER)))
    else $error("non-zero edge value on a top border row");
`endif

endmodule
